// ===== hw/rtl/kfsm_pkg.sv =====
// Shared types, codes and defaults for the scalar-measurement Kalman filter.
// Used by the controller, the datapath, the top level and the port checker.
`default_nettype none

package kfsm_pkg;

  localparam int MAX_STATES_DEF = 4;
  localparam int MAX_NOISE_DEF  = 4;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int WORD_W    = 32;
  localparam int SIZE_W    = 4;
  localparam int RNOISE_W  = 31;
  localparam int CNT_W     = 4;
  localparam int CFG_IDX_W = 2;

  localparam int IN_TDATA_W  = 104;
  localparam int IN_TUSER_W  = 4;
  localparam int OUT_TDATA_W = 72;

  localparam logic [CFG_IDX_W-1:0] CFG_STATE_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE = 2'd2;

  localparam logic [SIZE_W-1:0]   STATE_SIZE_RST = 4'd4;
  localparam logic [SIZE_W-1:0]   NOISE_SIZE_RST = 4'd4;
  localparam logic [RNOISE_W-1:0] MEAS_NOISE_RST = 31'd65536;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  localparam logic [2:0] TGT_F = 3'd0;
  localparam logic [2:0] TGT_D = 3'd1;
  localparam logic [2:0] TGT_B = 3'd2;
  localparam logic [2:0] TGT_Q = 3'd3;
  localparam logic [2:0] TGT_H = 3'd4;
  localparam logic [2:0] TGT_X = 3'd5;
  localparam logic [2:0] TGT_P = 3'd6;

  typedef enum logic [3:0] {
    PH_XP, PH_C, PH_P1, PH_S, PH_BQB, PH_CC, PH_V,
    PH_DIV, PH_PU, PH_E, PH_X, PH_OUT
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MAC, ST_DRAIN, ST_WRITE, ST_DIV_GO, ST_DIV_WAIT, ST_EMIT
  } state_t;

  typedef struct packed {
    logic             load;
    logic             step;
    logic             mac;
    logic             clr;
    logic             wr;
    logic             div_go;
    logic             emit;
    logic             last;
    phase_t           phase;
    logic [CNT_W-1:0] i;
    logic [CNT_W-1:0] j;
    logic [CNT_W-1:0] k;
  } dp_cmd_t;

  typedef struct packed {
    logic fault;
    logic div_done;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/kfsm_div.sv =====
// Radix-2 restoring divider for the gain: round(num * 2^FRAC_BITS / den).
// Depends on kfsm_pkg for the word width.
`default_nettype none

module kfsm_div #(
  parameter int FRAC_BITS = kfsm_pkg::FRAC_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  input  wire logic signed [kfsm_pkg::WORD_W-1:0] num,
  input  wire logic        [kfsm_pkg::WORD_W-1:0] den,
  output logic                                    done,
  output logic signed [kfsm_pkg::WORD_W-1:0]      quot
);

  localparam int W   = kfsm_pkg::WORD_W;
  localparam int DW  = W + FRAC_BITS + 1;
  localparam int CW  = $clog2(DW + 1);

  logic [DW-1:0] quo_r, quo_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  den_r;
  logic          neg_r;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  logic [W-1:0]  mag;
  logic [DW-1:0] dividend;
  logic [W:0]    trial;
  logic [W:0]    diff;

  always_comb begin
    mag      = num[W-1] ? W'(-num) : W'(num);
    dividend = DW'({mag, {FRAC_BITS{1'b0}}}) + DW'(den >> 1);
    trial    = {rem_r, quo_r[DW-1]};
    diff     = trial - {1'b0, den_r};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end else if (busy_r) begin
      if (!diff[W]) begin
        rem_nxt = diff[W-1:0];
        quo_nxt = {quo_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[W-1:0];
        quo_nxt = {quo_r[DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(DW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      den_r <= den;
      neg_r <= num[W-1];
    end
  end

  // Apply sign, saturate to a word.
  always_comb begin
    if (neg_r) begin
      if (quo_r > DW'(33'h080000000)) quot = {1'b1, {(W-1){1'b0}}};
      else                           quot = W'(-quo_r);
    end else begin
      if (quo_r > DW'(32'h7fffffff))  quot = {1'b0, {(W-1){1'b1}}};
      else                           quot = W'(quo_r);
    end
  end

  assign done = done_r;

endmodule

`default_nettype wire

// ===== hw/rtl/kfsm_dp.sv =====
// Datapath: model tables, scratch storage, one shared MAC, divider, result register.
// Depends on kfsm_pkg and kfsm_div; driven by kfsm_ctrl through dp_cmd_t.
`default_nettype none

module kfsm_dp #(
  parameter int MAX_STATES = kfsm_pkg::MAX_STATES_DEF,
  parameter int MAX_NOISE  = kfsm_pkg::MAX_NOISE_DEF,
  parameter int FRAC_BITS  = kfsm_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire kfsm_pkg::dp_cmd_t                    cmd,
  input  wire logic [2:0]                           in_target,
  input  wire logic [2:0]                           in_row,
  input  wire logic [2:0]                           in_col,
  input  wire logic signed [kfsm_pkg::WORD_W-1:0]   in_value,
  input  wire logic signed [kfsm_pkg::WORD_W-1:0]   in_measurement,
  input  wire logic signed [kfsm_pkg::WORD_W-1:0]   in_drive,
  input  wire logic [kfsm_pkg::RNOISE_W-1:0]        meas_noise,
  input  wire logic                                 out_ready,
  output kfsm_pkg::dp_stat_t                        stat,
  output logic                                      out_valid,
  output logic signed [kfsm_pkg::WORD_W-1:0]        out_estimate,
  output logic signed [kfsm_pkg::WORD_W-1:0]        out_gain,
  output logic [2:0]                                out_index,
  output logic                                      out_last,
  output logic                                      out_fault
);

  localparam int W  = kfsm_pkg::WORD_W;
  localparam int SW = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
  localparam int NW = (MAX_NOISE > 1) ? $clog2(MAX_NOISE) : 1;
  localparam int CW = kfsm_pkg::CNT_W;

  // Model tables
  logic signed [W-1:0] f_r [MAX_STATES][MAX_STATES];
  logic signed [W-1:0] d_r [MAX_STATES];
  logic signed [W-1:0] b_r [MAX_STATES][MAX_NOISE];
  logic signed [W-1:0] q_r [MAX_NOISE][MAX_NOISE];
  logic signed [W-1:0] h_r [MAX_STATES];
  logic signed [W-1:0] x_r [MAX_STATES];
  logic signed [W-1:0] p_r [MAX_STATES][MAX_STATES];

  // Step scratch
  logic signed [W-1:0] c_r  [MAX_STATES][MAX_STATES];
  logic signed [W-1:0] p1_r [MAX_STATES][MAX_STATES];
  logic signed [W-1:0] s_r  [MAX_STATES][MAX_NOISE];
  logic signed [W-1:0] xp_r [MAX_STATES];
  logic signed [W-1:0] cc_r [MAX_STATES];
  logic signed [W-1:0] g_r  [MAX_STATES];
  logic signed [W-1:0] z_r, u_r, e_r;
  logic signed [W+1:0] v_r;
  logic                fault_r;

  logic signed [2*W-1:0] prod_r, acc_r;
  logic                  mac_v_r, clr_r;

  logic signed [W-1:0] op_a, op_b, nar, div_q;
  logic [SW-1:0] i_s, j_s, k_s, km1_s, row_s, col_s;
  logic [NW-1:0] j_n, k_n, row_n, col_n;
  logic [CW-1:0] km1;
  logic          row_ok_s, col_ok_s, row_ok_n, col_ok_n;
  logic          div_done;

  logic                out_valid_r;
  logic signed [W-1:0] out_est_r, out_gain_r;
  logic [2:0]          out_index_r;
  logic                out_last_r, out_fault_r;

  function automatic logic signed [2*W-1:0] add_sat(input logic signed [2*W-1:0] a,
                                                    input logic signed [2*W-1:0] b);
    logic signed [2*W-1:0] s;
    s = a + b;
    if (a[2*W-1] == b[2*W-1] && s[2*W-1] != a[2*W-1])
      s = a[2*W-1] ? {1'b1, {(2*W-1){1'b0}}} : {1'b0, {(2*W-1){1'b1}}};
    return s;
  endfunction

  function automatic logic signed [W-1:0] sat_wide(input logic signed [2*W-1:0] v);
    logic signed [W-1:0] r;
    if (v > $signed({{(W+1){1'b0}}, {(W-1){1'b1}}}))     r = {1'b0, {(W-1){1'b1}}};
    else if (v < $signed({{(W+1){1'b1}}, {(W-1){1'b0}}})) r = {1'b1, {(W-1){1'b0}}};
    else                                                  r = v[W-1:0];
    return r;
  endfunction

  function automatic logic signed [W-1:0] sat_one(input logic signed [W:0] v);
    logic signed [W-1:0] r;
    if (v[W] != v[W-1]) r = v[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    else                r = v[W-1:0];
    return r;
  endfunction

  // Round half up, back to a word.
  function automatic logic signed [W-1:0] narrow(input logic signed [2*W-1:0] acc);
    logic signed [2*W-1:0] v;
    v = add_sat(acc, (2*W)'(1) <<< (FRAC_BITS - 1));
    return sat_wide(v >>> FRAC_BITS);
  endfunction

  always_comb begin
    i_s      = cmd.i[SW-1:0];
    j_s      = cmd.j[SW-1:0];
    k_s      = cmd.k[SW-1:0];
    km1      = cmd.k - 1'b1;
    km1_s    = km1[SW-1:0];
    j_n      = cmd.j[NW-1:0];
    k_n      = cmd.k[NW-1:0];
    row_s    = in_row[SW-1:0];
    col_s    = in_col[SW-1:0];
    row_n    = in_row[NW-1:0];
    col_n    = in_col[NW-1:0];
    row_ok_s = {1'b0, in_row} < 4'(MAX_STATES);
    col_ok_s = {1'b0, in_col} < 4'(MAX_STATES);
    row_ok_n = {1'b0, in_row} < 4'(MAX_NOISE);
    col_ok_n = {1'b0, in_col} < 4'(MAX_NOISE);
  end

  // Operand select for the shared multiplier
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cmd.phase)
      kfsm_pkg::PH_XP: begin
        if (cmd.k == '0) begin
          op_a = d_r[i_s];
          op_b = u_r;
        end else begin
          op_a = f_r[i_s][km1_s];
          op_b = x_r[km1_s];
        end
      end
      kfsm_pkg::PH_C: begin
        op_a = f_r[i_s][k_s];
        op_b = p_r[k_s][j_s];
      end
      kfsm_pkg::PH_P1: begin
        op_a = c_r[i_s][k_s];
        op_b = f_r[j_s][k_s];
      end
      kfsm_pkg::PH_S: begin
        op_a = b_r[i_s][k_n];
        op_b = q_r[k_n][j_n];
      end
      kfsm_pkg::PH_BQB: begin
        op_a = s_r[i_s][k_n];
        op_b = b_r[j_s][k_n];
      end
      kfsm_pkg::PH_CC: begin
        op_a = p1_r[i_s][k_s];
        op_b = h_r[k_s];
      end
      kfsm_pkg::PH_V: begin
        op_a = cc_r[k_s];
        op_b = h_r[k_s];
      end
      kfsm_pkg::PH_PU: begin
        op_a = g_r[i_s];
        op_b = cc_r[j_s];
      end
      kfsm_pkg::PH_E: begin
        op_a = h_r[k_s];
        op_b = xp_r[k_s];
      end
      kfsm_pkg::PH_X: begin
        op_a = g_r[i_s];
        op_b = e_r;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // Multiply into prod_r, then accumulate the registered product
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mac_v_r <= 1'b0;
      clr_r   <= 1'b0;
    end else begin
      mac_v_r <= cmd.mac;
      clr_r   <= cmd.clr;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= (2*W)'(op_a) * (2*W)'(op_b);
    if (mac_v_r) acc_r <= clr_r ? prod_r : add_sat(acc_r, prod_r);
  end

  assign nar = narrow(acc_r);

  // Tables without reset
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      case (in_target)
        kfsm_pkg::TGT_F: if (row_ok_s && col_ok_s) f_r[row_s][col_s] <= in_value;
        kfsm_pkg::TGT_D: if (row_ok_s) d_r[row_s] <= in_value;
        kfsm_pkg::TGT_B: if (row_ok_s && col_ok_n) b_r[row_s][col_n] <= in_value;
        kfsm_pkg::TGT_Q: if (row_ok_n && col_ok_n) q_r[row_n][col_n] <= in_value;
        kfsm_pkg::TGT_H: if (row_ok_s) h_r[row_s] <= in_value;
        default: ;
      endcase
    end
  end

  // Estimate and covariance clear at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < MAX_STATES; r++) begin
        x_r[r] <= '0;
        for (int c = 0; c < MAX_STATES; c++) p_r[r][c] <= '0;
      end
    end else begin
      if (cmd.load && in_target == kfsm_pkg::TGT_X && row_ok_s) x_r[row_s] <= in_value;
      if (cmd.load && in_target == kfsm_pkg::TGT_P && row_ok_s && col_ok_s)
        p_r[row_s][col_s] <= in_value;
      if (cmd.wr && cmd.phase == kfsm_pkg::PH_PU)
        p_r[i_s][j_s] <= sat_one({p1_r[i_s][j_s][W-1], p1_r[i_s][j_s]} - {nar[W-1], nar});
      if (cmd.wr && cmd.phase == kfsm_pkg::PH_X)
        x_r[i_s] <= sat_one({xp_r[i_s][W-1], xp_r[i_s]} + {nar[W-1], nar});
    end
  end

  // Scratch write-back
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      z_r <= in_measurement;
      u_r <= in_drive;
    end
    if (div_done) g_r[i_s] <= div_q;
    if (cmd.wr) begin
      case (cmd.phase)
        kfsm_pkg::PH_XP:  xp_r[i_s] <= nar;
        kfsm_pkg::PH_C:   c_r[i_s][j_s] <= nar;
        kfsm_pkg::PH_P1:  p1_r[i_s][j_s] <= nar;
        kfsm_pkg::PH_S:   s_r[i_s][j_n] <= nar;
        kfsm_pkg::PH_BQB:
          p1_r[i_s][j_s] <= sat_one({p1_r[i_s][j_s][W-1], p1_r[i_s][j_s]} + {nar[W-1], nar});
        kfsm_pkg::PH_CC:  cc_r[i_s] <= nar;
        kfsm_pkg::PH_V:   v_r <= $signed({3'b000, meas_noise}) + {{2{nar[W-1]}}, nar};
        kfsm_pkg::PH_E:   e_r <= sat_one({z_r[W-1], z_r} - {nar[W-1], nar});
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) fault_r <= 1'b0;
    else if (cmd.wr && cmd.phase == kfsm_pkg::PH_V)
      fault_r <= ($signed({3'b000, meas_noise}) + $signed({{2{nar[W-1]}}, nar})) <= 0;
  end

  kfsm_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_go),
    .num   (cc_r[i_s]),
    .den   (v_r[W-1:0]),
    .done  (div_done),
    .quot  (div_q)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.emit) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_est_r   <= x_r[i_s];
      out_gain_r  <= fault_r ? '0 : g_r[i_s];
      out_index_r <= cmd.i[2:0];
      out_last_r  <= cmd.last;
      out_fault_r <= fault_r;
    end
  end

  always_comb begin
    stat.fault    = fault_r;
    stat.div_done = div_done;
    stat.out_free = !out_valid_r || out_ready;
  end

  assign out_valid    = out_valid_r;
  assign out_estimate = out_est_r;
  assign out_gain     = out_gain_r;
  assign out_index    = out_index_r;
  assign out_last     = out_last_r;
  assign out_fault    = out_fault_r;

endmodule

`default_nettype wire

// ===== hw/rtl/kfsm_ctrl.sv =====
// Step sequencer: walks the filter phases and the i/j/k loop counters.
// Depends on kfsm_pkg; issues dp_cmd_t to kfsm_dp and reads dp_stat_t back.
`default_nettype none

module kfsm_ctrl #(
  parameter int MAX_STATES = kfsm_pkg::MAX_STATES_DEF,
  parameter int MAX_NOISE  = kfsm_pkg::MAX_NOISE_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  input  wire logic                          in_op,
  input  wire logic [kfsm_pkg::SIZE_W-1:0]   state_size,
  input  wire logic [kfsm_pkg::SIZE_W-1:0]   noise_size,
  input  wire kfsm_pkg::dp_stat_t            stat,
  output logic                               in_ready,
  output kfsm_pkg::dp_cmd_t                  cmd
);

  localparam int CW = kfsm_pkg::CNT_W;

  kfsm_pkg::state_t state_r, state_nxt;
  kfsm_pkg::phase_t phase_r, phase_nxt;
  logic [CW-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [CW-1:0] n, m, ni, nj, nk;

  always_comb begin
    if (state_size == '0)                      n = CW'(1);
    else if (state_size > CW'(MAX_STATES))     n = CW'(MAX_STATES);
    else                                       n = CW'(state_size);
    if (noise_size == '0)                      m = CW'(1);
    else if (noise_size > CW'(MAX_NOISE))      m = CW'(MAX_NOISE);
    else                                       m = CW'(noise_size);
  end

  // Loop bounds per phase
  always_comb begin
    ni = n;
    nj = CW'(1);
    nk = n;
    case (phase_r)
      kfsm_pkg::PH_XP:  nk = n + 1'b1;
      kfsm_pkg::PH_C:   nj = n;
      kfsm_pkg::PH_P1:  nj = n;
      kfsm_pkg::PH_S: begin
        nj = m;
        nk = m;
      end
      kfsm_pkg::PH_BQB: begin
        nj = n;
        nk = m;
      end
      kfsm_pkg::PH_V:   ni = CW'(1);
      kfsm_pkg::PH_E:   ni = CW'(1);
      kfsm_pkg::PH_PU: begin
        nj = n;
        nk = CW'(1);
      end
      kfsm_pkg::PH_X:   nk = CW'(1);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kfsm_pkg::ST_IDLE;
      phase_r <= kfsm_pkg::PH_XP;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.phase = phase_r;
    cmd.i     = i_r;
    cmd.j     = j_r;
    cmd.k     = k_r;
    case (state_r)
      kfsm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_op == kfsm_pkg::OP_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            cmd.step  = 1'b1;
            phase_nxt = kfsm_pkg::PH_XP;
            state_nxt = kfsm_pkg::ST_MAC;
            i_nxt     = '0;
            j_nxt     = '0;
            k_nxt     = '0;
          end
        end
      end
      kfsm_pkg::ST_MAC: begin
        cmd.mac = 1'b1;
        cmd.clr = (k_r == '0);
        if (k_r == nk - 1'b1) begin
          k_nxt     = '0;
          state_nxt = kfsm_pkg::ST_DRAIN;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      kfsm_pkg::ST_DRAIN: begin
        state_nxt = kfsm_pkg::ST_WRITE;
      end
      kfsm_pkg::ST_WRITE: begin
        cmd.wr    = 1'b1;
        state_nxt = kfsm_pkg::ST_MAC;
        if (j_r != nj - 1'b1) begin
          j_nxt = j_r + 1'b1;
        end else begin
          j_nxt = '0;
          if (i_r != ni - 1'b1) begin
            i_nxt = i_r + 1'b1;
          end else begin
            i_nxt = '0;
            case (phase_r)
              kfsm_pkg::PH_XP:  phase_nxt = kfsm_pkg::PH_C;
              kfsm_pkg::PH_C:   phase_nxt = kfsm_pkg::PH_P1;
              kfsm_pkg::PH_P1:  phase_nxt = kfsm_pkg::PH_S;
              kfsm_pkg::PH_S:   phase_nxt = kfsm_pkg::PH_BQB;
              kfsm_pkg::PH_BQB: phase_nxt = kfsm_pkg::PH_CC;
              kfsm_pkg::PH_CC:  phase_nxt = kfsm_pkg::PH_V;
              kfsm_pkg::PH_V: begin
                phase_nxt = kfsm_pkg::PH_DIV;
                state_nxt = kfsm_pkg::ST_DIV_GO;
              end
              kfsm_pkg::PH_PU:  phase_nxt = kfsm_pkg::PH_E;
              kfsm_pkg::PH_E:   phase_nxt = kfsm_pkg::PH_X;
              default: begin
                phase_nxt = kfsm_pkg::PH_OUT;
                state_nxt = kfsm_pkg::ST_EMIT;
              end
            endcase
          end
        end
      end
      kfsm_pkg::ST_DIV_GO: begin
        if (stat.fault) begin
          phase_nxt = kfsm_pkg::PH_OUT;
          state_nxt = kfsm_pkg::ST_EMIT;
          i_nxt     = '0;
        end else begin
          cmd.div_go = 1'b1;
          state_nxt  = kfsm_pkg::ST_DIV_WAIT;
        end
      end
      kfsm_pkg::ST_DIV_WAIT: begin
        if (stat.div_done) begin
          if (i_r == n - 1'b1) begin
            i_nxt     = '0;
            phase_nxt = kfsm_pkg::PH_PU;
            state_nxt = kfsm_pkg::ST_MAC;
          end else begin
            i_nxt     = i_r + 1'b1;
            state_nxt = kfsm_pkg::ST_DIV_GO;
          end
        end
      end
      kfsm_pkg::ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          cmd.last = (i_r == n - 1'b1);
          if (i_r == n - 1'b1) begin
            i_nxt     = '0;
            state_nxt = kfsm_pkg::ST_IDLE;
          end else begin
            i_nxt = i_r + 1'b1;
          end
        end
      end
      default: state_nxt = kfsm_pkg::ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/kalman_filter_scalar_measurement.sv =====
// Discrete Kalman filter with a scalar measurement, Q16.16 by default.
// Input stream carries load and step requests; result stream carries one
// request per state element of a step (estimate, gain, index, last, fault).
// Configuration: cfg_wen/cfg_index/cfg_wdata write state_size, noise_size and
// the measurement noise R; write only while the block is idle.
// Load requests produce nothing and in_tready stays high, so
// loads can follow back to back. A step request is worked on alone: in_tready
// stays low until its last result has entered the output register.
// Each dot product runs on the single shared MAC and each gain takes a pass
// through the bit-serial divider; these two set the length of a step. A
// faulted step skips the divider and the update.
// Reset (synchronous, rst_n low) clears estimate and covariance to zero and
// restores the configuration defaults; F, D, B, Q, H must be loaded before
// use. When out_tready is low the output register holds its request and
// the sequencer waits before emitting the next element.
`default_nettype none

module kalman_filter_scalar_measurement #(
  parameter int MAX_STATES = kfsm_pkg::MAX_STATES_DEF,
  parameter int MAX_NOISE  = kfsm_pkg::MAX_NOISE_DEF,
  parameter int FRAC_BITS  = kfsm_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  // row[2:0], col[5:3], value[37:6], measurement[69:38], drive[101:70], zero pad
  input  wire logic [kfsm_pkg::IN_TDATA_W-1:0]      in_tdata,
  // operation[0], target[3:1]
  input  wire logic [kfsm_pkg::IN_TUSER_W-1:0]      in_tuser,
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  // estimate[31:0], gain[63:32], index[66:64], zero pad
  output logic [kfsm_pkg::OUT_TDATA_W-1:0]          out_tdata,
  output logic                                      out_tlast,
  // fault[0]
  output logic [0:0]                                out_tuser,
  input  wire logic                                 cfg_wen,
  input  wire logic [kfsm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [kfsm_pkg::RNOISE_W-1:0]        cfg_wdata
);

  localparam int W = kfsm_pkg::WORD_W;

  logic [kfsm_pkg::SIZE_W-1:0]   state_size_r;
  logic [kfsm_pkg::SIZE_W-1:0]   noise_size_r;
  logic [kfsm_pkg::RNOISE_W-1:0] meas_noise_r;

  kfsm_pkg::dp_cmd_t  cmd;
  kfsm_pkg::dp_stat_t stat;

  logic signed [W-1:0] est, gain;
  logic [2:0]          idx;
  logic                fault;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_size_r <= kfsm_pkg::STATE_SIZE_RST;
      noise_size_r <= kfsm_pkg::NOISE_SIZE_RST;
      meas_noise_r <= kfsm_pkg::MEAS_NOISE_RST;
    end else if (cfg_wen) begin
      case (cfg_index)
        kfsm_pkg::CFG_STATE_SIZE: state_size_r <= cfg_wdata[kfsm_pkg::SIZE_W-1:0];
        kfsm_pkg::CFG_NOISE_SIZE: noise_size_r <= cfg_wdata[kfsm_pkg::SIZE_W-1:0];
        kfsm_pkg::CFG_MEAS_NOISE: meas_noise_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  kfsm_ctrl #(
    .MAX_STATES (MAX_STATES),
    .MAX_NOISE  (MAX_NOISE)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_op      (in_tuser[0]),
    .state_size (state_size_r),
    .noise_size (noise_size_r),
    .stat       (stat),
    .in_ready   (in_tready),
    .cmd        (cmd)
  );

  kfsm_dp #(
    .MAX_STATES (MAX_STATES),
    .MAX_NOISE  (MAX_NOISE),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_target      (in_tuser[3:1]),
    .in_row         (in_tdata[2:0]),
    .in_col         (in_tdata[5:3]),
    .in_value       (in_tdata[37:6]),
    .in_measurement (in_tdata[69:38]),
    .in_drive       (in_tdata[101:70]),
    .meas_noise     (meas_noise_r),
    .out_ready      (out_tready),
    .stat           (stat),
    .out_valid      (out_tvalid),
    .out_estimate   (est),
    .out_gain       (gain),
    .out_index      (idx),
    .out_last       (out_tlast),
    .out_fault      (fault)
  );

  assign out_tdata = {5'b00000, idx, gain, est};
  assign out_tuser = fault;

endmodule

`default_nettype wire

// ===== hw/rtl/kfsm_chk.sv =====
// Port-level checker for kalman_filter_scalar_measurement, bound to the top.
// Depends on kfsm_pkg for port widths.
`default_nettype none

module kfsm_chk (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_tvalid,
  input wire logic                             in_tready,
  input wire logic [kfsm_pkg::IN_TUSER_W-1:0]  in_tuser,
  input wire logic                             out_tvalid,
  input wire logic                             out_tready,
  input wire logic [kfsm_pkg::OUT_TDATA_W-1:0] out_tdata,
  input wire logic                             out_tlast,
  input wire logic [0:0]                       out_tuser
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  // A faulted step reports zero gain.
  a_fault_gain: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[63:32] == 32'd0)
    else $error("nonzero gain on fault");

  // A step request blocks the input the next cycle.
  a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser[0] == kfsm_pkg::OP_STEP |=> !in_tready)
    else $error("input taken during step");

  // A load request produces no result.
  a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser[0] == kfsm_pkg::OP_LOAD && !out_tvalid
    |=> !out_tvalid)
    else $error("result after load");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) $past(!rst_n) |-> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind kalman_filter_scalar_measurement kfsm_chk u_kfsm_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking bench for kalman_filter_scalar_measurement: drives load and step
// requests, predicts every estimate/gain result in Q16.16 and compares them.
// Depends on kfsm_pkg and the filter RTL only.
`timescale 1ns / 100ps
`default_nettype none

module tb_top;

  localparam int NS = kfsm_pkg::MAX_STATES_DEF;
  localparam int NM = kfsm_pkg::MAX_NOISE_DEF;
  localparam int FB = kfsm_pkg::FRAC_BITS_DEF;
  localparam logic [2:0] TGT_NONE = 3'd7;   // unused table code, must be ignored
  localparam longint CYCLE_LIMIT = 3000000;
  localparam longint S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint S64_MIN = -64'sh7FFF_FFFF_FFFF_FFFF - 1;

  logic clk, rst_n;
  logic in_tvalid, in_tready;
  logic [kfsm_pkg::IN_TDATA_W-1:0] in_tdata;   // row, col, value, measurement, drive, zero pad
  logic [kfsm_pkg::IN_TUSER_W-1:0] in_tuser;   // operation, target
  logic out_tvalid, out_tready;
  logic [kfsm_pkg::OUT_TDATA_W-1:0] out_tdata; // estimate, gain, index, zero pad
  logic out_tlast;
  logic [0:0] out_tuser;                       // fault
  logic cfg_wen;
  logic [kfsm_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [kfsm_pkg::RNOISE_W-1:0] cfg_wdata;

  kalman_filter_scalar_measurement DUT (.*);

  // One expected result request of a step.
  typedef struct {
    int         estimate;
    int         gain;
    logic [2:0] index;
    logic       last;
    logic       fault;
  } filt_result_t;

  filt_result_t pending_results[$];

  // Shadow copy of the filter tables and registers.
  int f_mat[NS][NS], d_vec[NS], b_mat[NS][NM], q_mat[NM][NM], h_vec[NS];
  int x_est[NS], p_cov[NS][NS];
  logic [kfsm_pkg::SIZE_W-1:0] n_reg, m_reg;
  logic [kfsm_pkg::RNOISE_W-1:0] r_reg;

  int  errors;
  bit  idle_mode;   // when set both sides insert random gaps
  longint cycles;
  int  hold_cnt;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------- fixed-point helpers ----------------
  function automatic longint add_sat(longint a, longint b);
    longint s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) return a[63] ? S64_MIN : S64_MAX;
    return s;
  endfunction

  function automatic int sat32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return int'(v);
  endfunction

  function automatic longint prod(int a, int b);
    return longint'(a) * longint'(b);
  endfunction

  // Round half up and bring a 2*FB fraction sum back to a word.
  function automatic int to_word(longint acc);
    longint v;
    v = add_sat(acc, longint'(1) <<< (FB - 1));
    return sat32(v >>> FB);
  endfunction

  function automatic int clamp_size(logic [kfsm_pkg::SIZE_W-1:0] s, int mx);
    if (s < 1) return 1;
    if (s > mx) return mx;
    return int'(s);
  endfunction

  // ---------------- predictor ----------------
  function automatic void apply_load(logic [2:0] tgt, int r, int c, int v);
    case (tgt)
      kfsm_pkg::TGT_F: if (r < NS && c < NS) f_mat[r][c] = v;
      kfsm_pkg::TGT_D: if (r < NS) d_vec[r] = v;
      kfsm_pkg::TGT_B: if (r < NS && c < NM) b_mat[r][c] = v;
      kfsm_pkg::TGT_Q: if (r < NM && c < NM) q_mat[r][c] = v;
      kfsm_pkg::TGT_H: if (r < NS) h_vec[r] = v;
      kfsm_pkg::TGT_X: if (r < NS) x_est[r] = v;
      kfsm_pkg::TGT_P: if (r < NS && c < NS) p_cov[r][c] = v;
      default: ;
    endcase
  endfunction

  // Run one filter step on the shadow state and queue its results.
  function automatic void predict_step(int z, int u);
    int n, m, e;
    int xp[NS], cc[NS], g[NS];
    int c[NS][NS], p1[NS][NS], s[NS][NM];
    longint acc, v, num;
    longint unsigned mag, q;
    bit fault;
    filt_result_t res;
    n = clamp_size(n_reg, NS);
    m = clamp_size(m_reg, NM);
    fault = 1'b0;
    for (int i = 0; i < n; i++) begin
      acc = prod(d_vec[i], u);
      for (int j = 0; j < n; j++) acc = add_sat(acc, prod(f_mat[i][j], x_est[j]));
      xp[i] = to_word(acc);
    end
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++) begin
        acc = 0;
        for (int k = 0; k < n; k++) acc = add_sat(acc, prod(f_mat[i][k], p_cov[k][j]));
        c[i][j] = to_word(acc);
      end
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++) begin
        acc = 0;
        for (int k = 0; k < n; k++) acc = add_sat(acc, prod(c[i][k], f_mat[j][k]));
        p1[i][j] = to_word(acc);
      end
    for (int i = 0; i < n; i++)
      for (int j = 0; j < m; j++) begin
        acc = 0;
        for (int k = 0; k < m; k++) acc = add_sat(acc, prod(b_mat[i][k], q_mat[k][j]));
        s[i][j] = to_word(acc);
      end
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++) begin
        acc = 0;
        for (int k = 0; k < m; k++) acc = add_sat(acc, prod(s[i][k], b_mat[j][k]));
        p1[i][j] = sat32(longint'(p1[i][j]) + to_word(acc));
      end
    for (int i = 0; i < n; i++) begin
      acc = 0;
      for (int k = 0; k < n; k++) acc = add_sat(acc, prod(p1[i][k], h_vec[k]));
      cc[i] = to_word(acc);
    end
    acc = 0;
    for (int i = 0; i < n; i++) acc = add_sat(acc, prod(cc[i], h_vec[i]));
    v = longint'(r_reg) + to_word(acc);

    if (v <= 0) begin
      fault = 1'b1;
      for (int i = 0; i < n; i++) g[i] = 0;
    end else begin
      for (int i = 0; i < n; i++) begin
        num = longint'(cc[i]) * (longint'(1) <<< FB);
        mag = (num < 0) ? longint'(-num) : num;
        q = (mag + longint'(v) / 2) / longint'(v);
        g[i] = sat32((num < 0) ? -longint'(q) : longint'(q));
      end
      for (int i = 0; i < n; i++)
        for (int j = 0; j < n; j++)
          p_cov[i][j] = sat32(longint'(p1[i][j]) - to_word(prod(g[i], cc[j])));
      acc = 0;
      for (int i = 0; i < n; i++) acc = add_sat(acc, prod(h_vec[i], xp[i]));
      e = sat32(longint'(z) - to_word(acc));
      for (int i = 0; i < n; i++) x_est[i] = sat32(longint'(xp[i]) + to_word(prod(g[i], e)));
    end

    for (int i = 0; i < n; i++) begin
      res.estimate = x_est[i];
      res.gain     = g[i];
      res.index    = i[2:0];
      res.last     = (i == n - 1);
      res.fault    = fault;
      pending_results.push_back(res);
    end
  endfunction

  // ---------------- stimulus helpers ----------------
  function automatic int pick_gap();
    int r;
    if (!idle_mode) return 0;
    r = $urandom_range(0, 9);
    if (r < 5) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Mostly modest Q16.16 values so steps stay meaningful; sometimes any word.
  function automatic int pick_word();
    if ($urandom_range(0, 7) == 0) return int'($urandom);
    return int'($urandom_range(0, 1 << 18)) - (1 << 17);
  endfunction

  // Send one request; valid stays high into the next call when no gap follows.
  task automatic send_request(logic op, logic [2:0] tgt, logic [2:0] r, logic [2:0] c,
                              int value, int z, int u);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= {tgt, op};
    in_tdata  <= {2'b00, u, z, value, c, r};
    do @(posedge clk); while (!in_tready);
    if (op == kfsm_pkg::OP_LOAD) apply_load(tgt, r, c, value);
    else predict_step(z, u);
  endtask

  task automatic load_word(logic [2:0] tgt, int r, int c, int v);
    send_request(kfsm_pkg::OP_LOAD, tgt, r[2:0], c[2:0], v, pick_word(), pick_word());
  endtask

  task automatic run_step(int z, int u);
    send_request(kfsm_pkg::OP_STEP, 3'(int'($urandom_range(0, 7))), 3'($urandom),
                 3'($urandom), int'($urandom), z, u);
  endtask

  // Hold until every expected result is in and the block has settled.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [kfsm_pkg::CFG_IDX_W-1:0] idx,
                           logic [kfsm_pkg::RNOISE_W-1:0] data);
    wait_idle();
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_wen <= 1'b0;
    case (idx)
      kfsm_pkg::CFG_STATE_SIZE: n_reg = data[kfsm_pkg::SIZE_W-1:0];
      kfsm_pkg::CFG_NOISE_SIZE: m_reg = data[kfsm_pkg::SIZE_W-1:0];
      kfsm_pkg::CFG_MEAS_NOISE: r_reg = data;
      default: ;
    endcase
  endtask

  // Load every model, estimate and covariance word so no step reads an unloaded entry.
  task automatic load_all(bit tame);
    for (int r = 0; r < NS; r++) begin
      for (int c = 0; c < NS; c++) begin
        load_word(kfsm_pkg::TGT_F, r, c, tame ? ((r == c) ? 32'h0001_0000 : 32'h0000_1000)
                                              : pick_word());
        load_word(kfsm_pkg::TGT_P, r, c, tame ? ((r == c) ? 32'h0002_0000 : 0)
                                              : pick_word());
      end
      for (int c = 0; c < NM; c++)
        load_word(kfsm_pkg::TGT_B, r, c, tame ? 32'h0000_8000 : pick_word());
      load_word(kfsm_pkg::TGT_D, r, 0, tame ? 32'h0000_4000 : pick_word());
      load_word(kfsm_pkg::TGT_H, r, 0, tame ? ((r == 0) ? 32'h0001_0000 : 0) : pick_word());
      load_word(kfsm_pkg::TGT_X, r, 0, tame ? 0 : pick_word());
    end
    for (int r = 0; r < NM; r++)
      for (int c = 0; c < NM; c++)
        load_word(kfsm_pkg::TGT_Q, r, c, tame ? ((r == c) ? 32'h0000_2000 : 0) : pick_word());
  endtask

  // ---------------- tests ----------------
  // Extremes of every field plus loads that must be dropped.
  task automatic test_directed_fields();
    load_all(1'b1);
    load_word(TGT_NONE, 0, 0, 32'h7FFF_FFFF);             // unknown table, ignored
    load_word(kfsm_pkg::TGT_F, 7, 0, 32'h8000_0000);      // row beyond the table
    load_word(kfsm_pkg::TGT_Q, 0, 7, 32'h8000_0000);      // column beyond the table
    load_word(kfsm_pkg::TGT_H, 4, 7, 32'hFFFF_FFFF);
    run_step(0, 0);
    run_step(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    run_step(32'h8000_0000, 32'h8000_0000);
    run_step(32'hFFFF_FFFF, 32'h0001_0000);
    load_word(kfsm_pkg::TGT_X, 1, 0, 32'h7FFF_FFFF);      // saturating prediction
    load_word(kfsm_pkg::TGT_D, 2, 0, 32'h8000_0000);
    run_step(32'h0003_0000, 32'h7FFF_FFFF);
  endtask

  // Sizes outside 1..MAX clamp; R at both ends.
  task automatic test_size_limits();
    write_reg(kfsm_pkg::CFG_STATE_SIZE, 31'd0);
    write_reg(kfsm_pkg::CFG_NOISE_SIZE, 31'd15);
    write_reg(kfsm_pkg::CFG_MEAS_NOISE, 31'h7FFF_FFFF);
    run_step(32'h0001_0000, 0);
    write_reg(kfsm_pkg::CFG_STATE_SIZE, 31'd15);
    write_reg(kfsm_pkg::CFG_NOISE_SIZE, 31'd0);
    write_reg(kfsm_pkg::CFG_MEAS_NOISE, 31'd1);
    run_step(32'h0002_0000, 32'h0000_8000);
    write_reg(kfsm_pkg::CFG_STATE_SIZE, 31'd2);
    write_reg(kfsm_pkg::CFG_NOISE_SIZE, 31'd3);
    run_step(32'hFFFE_0000, 32'h0001_0000);
  endtask

  // Zero R, zero covariance and zero noise give a zero innovation variance.
  task automatic test_innovation_fault();
    write_reg(kfsm_pkg::CFG_STATE_SIZE, 31'd4);
    write_reg(kfsm_pkg::CFG_NOISE_SIZE, 31'd4);
    write_reg(kfsm_pkg::CFG_MEAS_NOISE, 31'd0);
    for (int r = 0; r < NS; r++) begin
      for (int c = 0; c < NS; c++) load_word(kfsm_pkg::TGT_P, r, c, 0);
      for (int c = 0; c < NM; c++) load_word(kfsm_pkg::TGT_Q, r, c, 0);
    end
    run_step(32'h0005_0000, 32'h0001_0000);
    run_step(32'h8000_0000, 32'h7FFF_FFFF);
    write_reg(kfsm_pkg::CFG_MEAS_NOISE, 31'd65536);
  endtask

  // Random phases: reconfigure, rewrite a few model words, then steps and stray loads.
  task automatic test_random_phases();
    int items;
    items = 0;
    while (items < 30) begin
      write_reg(kfsm_pkg::CFG_STATE_SIZE, 31'($urandom_range(0, 15)));
      write_reg(kfsm_pkg::CFG_NOISE_SIZE, 31'($urandom_range(0, 15)));
      write_reg(kfsm_pkg::CFG_MEAS_NOISE, ($urandom_range(0, 3) == 0)
                                          ? 31'($urandom) : 31'($urandom_range(0, 1 << 18)));
      idle_mode = $urandom_range(0, 3) != 0;
      repeat ($urandom_range(2, 5)) begin
        load_word(3'($urandom_range(0, 6)), int'($urandom_range(0, NS - 1)),
                  int'($urandom_range(0, NS - 1)), pick_word());
        items++;
      end
      repeat ($urandom_range(6, 10)) begin
        if ($urandom_range(0, 4) == 0) begin
          send_request(kfsm_pkg::OP_LOAD, 3'($urandom), 3'($urandom), 3'($urandom),
                       pick_word(), int'($urandom), int'($urandom));
        end else begin
          run_step(pick_word(), pick_word());
        end
        items++;
      end
    end
  endtask

  // Sender holds off until the block has drained, then steps back to back.
  task automatic test_drain_pause();
    idle_mode = 1'b0;
    wait_idle();
    run_step(32'h0001_0000, 0);
    run_step(pick_word(), pick_word());
    idle_mode = 1'b1;
  endtask

  // ---------------- result checker and receiver stalls ----------------
  always @(posedge clk) begin
    filt_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result request estimate=%h", $time, out_tdata[31:0]);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[31:0] !== want.estimate) begin
          $display("%0t: estimate exp %h got %h", $time, want.estimate, out_tdata[31:0]);
          errors++;
        end
        if (out_tdata[63:32] !== want.gain) begin
          $display("%0t: gain exp %h got %h", $time, want.gain, out_tdata[63:32]);
          errors++;
        end
        if (out_tdata[66:64] !== want.index) begin
          $display("%0t: index exp %0d got %0d", $time, want.index, out_tdata[66:64]);
          errors++;
        end
        if (out_tlast !== want.last) begin
          $display("%0t: last exp %b got %b", $time, want.last, out_tlast);
          errors++;
        end
        if (out_tuser[0] !== want.fault) begin
          $display("%0t: fault exp %b got %b", $time, want.fault, out_tuser[0]);
          errors++;
        end
      end
    end
    // Receiver stalls: mostly short, now and then long.
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_tready <= 1'b0;
    end else if (idle_mode && $urandom_range(0, 3) == 0) begin
      hold_cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 2);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    errors = 0; cycles = 0; hold_cnt = 0; idle_mode = 1'b0;
    rst_n = 1'b0; in_tvalid = 1'b0; in_tdata = '0; in_tuser = '0;
    out_tready = 1'b1; cfg_wen = 1'b0; cfg_index = '0; cfg_wdata = '0;
    n_reg = kfsm_pkg::STATE_SIZE_RST;
    m_reg = kfsm_pkg::NOISE_SIZE_RST;
    r_reg = kfsm_pkg::MEAS_NOISE_RST;
    for (int r = 0; r < NS; r++) begin
      d_vec[r] = 0; h_vec[r] = 0; x_est[r] = 0;
      for (int c = 0; c < NS; c++) begin
        f_mat[r][c] = 0; p_cov[r][c] = 0;
      end
      for (int c = 0; c < NM; c++) b_mat[r][c] = 0;
    end
    for (int r = 0; r < NM; r++) for (int c = 0; c < NM; c++) q_mat[r][c] = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_fields();
    test_size_limits();
    test_innovation_fault();
    idle_mode = 1'b1;
    test_drain_pause();
    test_random_phases();

    wait_idle();
    repeat (1000) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
